// ===== rtl/gtg_pkg.sv =====
// ----------------------------------------------------------------------------
// gtg_pkg
// Widths, constants, tables and types shared by the go-to-goal controller.
// ----------------------------------------------------------------------------
package gtg_pkg;

   localparam int FRAC_BITS    = 12;
   localparam int CORDIC_STEPS = 16;

   localparam int IN_W     = 16;
   localparam int HEAD_W   = 15;
   localparam int RATE_W   = 15;
   localparam int CFG_W    = 16;
   localparam int D_W      = IN_W + 1;
   localparam int ROOT_W   = IN_W + 1;
   localparam int SUM_W    = 2 * ROOT_W;
   localparam int REM_W    = ROOT_W + 2;
   localparam int PRESCALE = 16;
   localparam int ANG_BITS = 30;
   localparam int CW       = D_W + PRESCALE + 3;
   localparam int ZW       = ANG_BITS + 4;
   localparam int BEAR_SHIFT = ANG_BITS - FRAC_BITS;
   localparam int BEAR_W   = ZW - BEAR_SHIFT;
   localparam int ERR_W    = ((BEAR_W > HEAD_W) ? BEAR_W : HEAD_W) + 1;
   localparam int PROD_W   = CFG_W + ROOT_W;
   localparam int TABLE_LEN = 24;
   localparam int N_CELLS  = (CORDIC_STEPS > ROOT_W) ? CORDIC_STEPS : ROOT_W;
   localparam int STEP_W   = $clog2(N_CELLS);
   localparam int CSR_INDEX_W = 2;

   localparam logic [ROOT_W-1:0] THR_DIST = ROOT_W'(((4 << FRAC_BITS) + 5) / 10);
   localparam logic [ERR_W-1:0]  THR_ANG  = ERR_W'(((2 << FRAC_BITS) + 5) / 10);
   localparam logic [RATE_W-1:0] RATE_MAX = {RATE_W{1'b1}};
   localparam logic [CFG_W-1:0]  CFG_RESET = CFG_W'(4096);

   localparam logic [ZW-1:0] HALF_PI_Q30 = ZW'(64'd1686629713);

   localparam logic [ZW-1:0] ATAN_Q30 [TABLE_LEN] = '{
      ZW'(64'd843314856), ZW'(64'd497837829), ZW'(64'd263043836), ZW'(64'd133525158),
      ZW'(64'd67021686),  ZW'(64'd33543515),  ZW'(64'd16775850),  ZW'(64'd8388437),
      ZW'(64'd4194282),   ZW'(64'd2097149),   ZW'(64'd1048575),   ZW'(64'd524287),
      ZW'(64'd262143),    ZW'(64'd131071),    ZW'(64'd65535),     ZW'(64'd32767),
      ZW'(64'd16383),     ZW'(64'd8191),      ZW'(64'd4095),      ZW'(64'd2047),
      ZW'(64'd1023),      ZW'(64'd511),       ZW'(64'd255),       ZW'(64'd127)
   };

   typedef enum logic [CSR_INDEX_W-1:0] {
      REG_DEST_X      = 2'd0,
      REG_DEST_Y      = 2'd1,
      REG_GAIN        = 2'd2,
      REG_SPEED_LIMIT = 2'd3
   } reg_index_type;

   typedef struct packed {
      logic signed [CW-1:0]     x;
      logic signed [CW-1:0]     y;
      logic signed [ZW-1:0]     z;
      logic        [SUM_W-1:0]  rad;
      logic        [REM_W-1:0]  rem;
      logic        [ROOT_W-1:0] root;
      logic signed [HEAD_W-1:0] heading;
   } cell_data_type;

endpackage

// ===== rtl/gtg_prep.sv =====
// ----------------------------------------------------------------------------
// gtg_prep
// Offset to target, squared distance and CORDIC pre-rotation, two stages.
// ----------------------------------------------------------------------------
module gtg_prep (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   output logic                          ready_out,
   input  logic [gtg_pkg::IN_W-1:0]      pos_x,
   input  logic [gtg_pkg::IN_W-1:0]      pos_y,
   input  logic [gtg_pkg::HEAD_W-1:0]    heading,
   input  logic [gtg_pkg::CFG_W-1:0]     dest_x,
   input  logic [gtg_pkg::CFG_W-1:0]     dest_y,
   output logic                          out_valid,
   output gtg_pkg::cell_data_type        out_data,
   input  logic                          ready_in
);
   import gtg_pkg::*;

   logic                     a_valid_ff;
   logic signed [D_W-1:0]    dx_ff, dy_ff;
   logic signed [HEAD_W-1:0] hd_ff;
   logic signed [D_W-1:0]    dx_in, dy_in;

   logic                     b_valid_ff;
   cell_data_type            b_data_ff;
   cell_data_type            b_data_in;

   logic                     ready_a, ready_b;
   logic signed [2*D_W-1:0]  sq_x, sq_y;
   logic signed [CW-1:0]     sx, sy;

   assign ready_b   = !b_valid_ff || ready_in;
   assign ready_a   = !a_valid_ff || ready_b;
   assign ready_out = ready_a;

   assign dx_in = $signed({1'b0, dest_x}) - $signed({1'b0, pos_x});
   assign dy_in = $signed({1'b0, dest_y}) - $signed({1'b0, pos_y});

   always_ff @(posedge clock) begin
      if (reset) begin
         a_valid_ff <= 1'b0;
      end else if (ready_a) begin
         a_valid_ff <= in_valid;
      end
      if (ready_a && in_valid) begin
         dx_ff <= dx_in;
         dy_ff <= dy_in;
         hd_ff <= $signed(heading);
      end
   end

   assign sq_x = dx_ff * dx_ff;
   assign sq_y = dy_ff * dy_ff;
   assign sx = {{(CW-D_W-PRESCALE){dx_ff[D_W-1]}}, dx_ff, {PRESCALE{1'b0}}};
   assign sy = {{(CW-D_W-PRESCALE){dy_ff[D_W-1]}}, dy_ff, {PRESCALE{1'b0}}};

   always_comb begin
      b_data_in.rad     = SUM_W'($unsigned(sq_x)) + SUM_W'($unsigned(sq_y));
      b_data_in.rem     = '0;
      b_data_in.root    = '0;
      b_data_in.heading = hd_ff;
      if (sx < 0) begin
         if (sy >= 0) begin
            b_data_in.x = sy;
            b_data_in.y = -sx;
            b_data_in.z = $signed(HALF_PI_Q30);
         end else begin
            b_data_in.x = -sy;
            b_data_in.y = sx;
            b_data_in.z = -$signed(HALF_PI_Q30);
         end
      end else begin
         b_data_in.x = sx;
         b_data_in.y = sy;
         b_data_in.z = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         b_valid_ff <= 1'b0;
      end else if (ready_b) begin
         b_valid_ff <= a_valid_ff;
      end
      if (ready_b && a_valid_ff) begin
         b_data_ff <= b_data_in;
      end
   end

   assign out_valid = b_valid_ff;
   assign out_data  = b_data_ff;

endmodule

// ===== rtl/gtg_cell.sv =====
// ----------------------------------------------------------------------------
// gtg_cell
// Chain cell: one sqrt digit; below step 16 also a CORDIC vectoring step.
// ----------------------------------------------------------------------------
module gtg_cell (
   input  logic                          clock,
   input  logic                          reset,
   input  logic [gtg_pkg::STEP_W-1:0]    step,
   input  logic                          in_valid,
   input  gtg_pkg::cell_data_type        in_data,
   output logic                          ready_out,
   output logic                          out_valid,
   output gtg_pkg::cell_data_type        out_data,
   input  logic                          ready_in
);
   import gtg_pkg::*;

   logic                  valid_ff;
   cell_data_type         data_ff;
   cell_data_type         data_in;
   logic signed [CW-1:0]  xs, ys;
   logic [REM_W+1:0]      shifted;
   logic [REM_W-1:0]      trial;

   assign xs      = in_data.x >>> step;
   assign ys      = in_data.y >>> step;
   assign shifted = {in_data.rem, in_data.rad[SUM_W-1 -: 2]};
   assign trial   = {in_data.root, 2'b01};

   always_comb begin
      data_in = in_data;
      if (step < STEP_W'(CORDIC_STEPS)) begin
         if (in_data.y > 0) begin
            data_in.x = in_data.x + ys;
            data_in.y = in_data.y - xs;
            data_in.z = in_data.z + $signed(ATAN_Q30[step]);
         end else begin
            data_in.x = in_data.x - ys;
            data_in.y = in_data.y + xs;
            data_in.z = in_data.z - $signed(ATAN_Q30[step]);
         end
      end
      if (step < STEP_W'(ROOT_W)) begin
         data_in.rad = {in_data.rad[SUM_W-3:0], 2'b00};
         if (shifted >= {2'b00, trial}) begin
            data_in.rem  = REM_W'(shifted - {2'b00, trial});
            data_in.root = {in_data.root[ROOT_W-2:0], 1'b1};
         end else begin
            data_in.rem  = shifted[REM_W-1:0];
            data_in.root = {in_data.root[ROOT_W-2:0], 1'b0};
         end
      end
   end

   assign ready_out = !valid_ff || ready_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (ready_out) begin
         valid_ff <= in_valid;
      end
      if (ready_out && in_valid) begin
         data_ff <= data_in;
      end
   end

   assign out_valid = valid_ff;
   assign out_data  = data_ff;

endmodule

// ===== rtl/gtg_out.sv =====
// ----------------------------------------------------------------------------
// gtg_out
// Angle error, command decision, speed product and clamped output register.
// ----------------------------------------------------------------------------
module gtg_out (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          in_valid,
   input  gtg_pkg::cell_data_type        in_data,
   output logic                          ready_out,
   input  logic [gtg_pkg::CFG_W-1:0]     gain,
   input  logic [gtg_pkg::CFG_W-1:0]     speed_limit,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [gtg_pkg::IN_W-1:0]      linear_speed,
   output logic [gtg_pkg::RATE_W-1:0]    angular_rate
);
   import gtg_pkg::*;

   logic signed [ZW-1:0]     z_round;
   logic signed [BEAR_W-1:0] bearing;
   logic signed [ERR_W-1:0]  err;
   logic [ERR_W-1:0]         abs_err;
   logic                     motion, turn_in, fwd_in;
   logic [RATE_W-1:0]        rate_in;
   logic [PROD_W-1:0]        prod_in;

   logic                     c_valid_ff, turn_ff, fwd_ff;
   logic [RATE_W-1:0]        rate_ff;
   logic [PROD_W-1:0]        prod_ff;

   logic [PROD_W-1:0]        scaled;
   logic [IN_W-1:0]          speed_in;
   logic [RATE_W-1:0]        rate_out_in;

   logic                     rsp_valid_ff;
   logic [IN_W-1:0]          speed_ff;
   logic [RATE_W-1:0]        rate_out_ff;

   logic                     ready_c, ready_d;

   assign z_round = in_data.z + $signed(ZW'(1) <<< (BEAR_SHIFT - 1));
   assign bearing = z_round[ZW-1:BEAR_SHIFT];
   assign err     = ERR_W'(bearing) - ERR_W'(in_data.heading);
   assign abs_err = (err < 0) ? ERR_W'(-err) : ERR_W'(err);
   assign motion  = in_data.root > THR_DIST;
   assign turn_in = motion && (abs_err > THR_ANG);
   assign fwd_in  = motion && !(abs_err > THR_ANG);
   assign rate_in = (abs_err > ERR_W'(RATE_MAX)) ? RATE_MAX : abs_err[RATE_W-1:0];
   assign prod_in = PROD_W'(gain) * PROD_W'(in_data.root);

   assign ready_d   = !rsp_valid_ff || !rsp_stall;
   assign ready_c   = !c_valid_ff || ready_d;
   assign ready_out = ready_c;

   always_ff @(posedge clock) begin
      if (reset) begin
         c_valid_ff <= 1'b0;
      end else if (ready_c) begin
         c_valid_ff <= in_valid;
      end
      if (ready_c && in_valid) begin
         turn_ff <= turn_in;
         fwd_ff  <= fwd_in;
         rate_ff <= rate_in;
         prod_ff <= prod_in;
      end
   end

   assign scaled = prod_ff >> FRAC_BITS;

   always_comb begin
      speed_in    = '0;
      rate_out_in = '0;
      if (fwd_ff) begin
         speed_in = (scaled > PROD_W'(speed_limit)) ? speed_limit : scaled[IN_W-1:0];
      end
      if (turn_ff) begin
         rate_out_in = rate_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (ready_d) begin
         rsp_valid_ff <= c_valid_ff;
      end
      if (ready_d && c_valid_ff) begin
         speed_ff    <= speed_in;
         rate_out_ff <= rate_out_in;
      end
   end

   assign rsp_valid    = rsp_valid_ff;
   assign linear_speed = speed_ff;
   assign angular_rate = rate_out_ff;

endmodule

// ===== rtl/go_to_goal_velocity_command.sv =====
// ----------------------------------------------------------------------------
// go_to_goal_velocity_command
// Proportional go-to-goal controller: distance by digit square root, bearing
// by CORDIC vectoring, both in one chain of cells, then turn or drive.
//
//   channel  ports                                   direction
//   req      req_valid req_stall req_pos_x/_y/_heading   in
//   rsp      rsp_valid rsp_stall rsp_linear_speed/_angular_rate  out
//   csr      csr_wr_en csr_index csr_wr_data              in
//
// One transaction enters per cycle while req_stall is low; the chain has
// N_CELLS cells, their number set by the 17 square-root digits.
// Every stage holds only while its successor is full and stalled.
// Synchronous reset clears all valid bits and loads the register defaults.
// ----------------------------------------------------------------------------
module go_to_goal_velocity_command (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic [gtg_pkg::IN_W-1:0]          req_pos_x,
   input  logic [gtg_pkg::IN_W-1:0]          req_pos_y,
   input  logic signed [gtg_pkg::HEAD_W-1:0] req_heading,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [gtg_pkg::IN_W-1:0]          rsp_linear_speed,
   output logic [gtg_pkg::RATE_W-1:0]        rsp_angular_rate,
   input  logic                              csr_wr_en,
   input  logic [gtg_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [gtg_pkg::CFG_W-1:0]         csr_wr_data
);
   import gtg_pkg::*;

   logic [CFG_W-1:0] dest_x_ff, dest_y_ff, gain_ff, speed_limit_ff;

   logic          chain_valid [N_CELLS+1];
   cell_data_type chain_data  [N_CELLS+1];
   logic          chain_ready [N_CELLS+1];
   logic          prep_ready;
   logic          out_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         dest_x_ff      <= CFG_RESET;
         dest_y_ff      <= CFG_RESET;
         gain_ff        <= CFG_RESET;
         speed_limit_ff <= CFG_RESET;
      end else if (csr_wr_en) begin
         unique case (reg_index_type'(csr_index))
            REG_DEST_X:      dest_x_ff      <= csr_wr_data;
            REG_DEST_Y:      dest_y_ff      <= csr_wr_data;
            REG_GAIN:        gain_ff        <= csr_wr_data;
            REG_SPEED_LIMIT: speed_limit_ff <= csr_wr_data;
         endcase
      end
   end

   assign req_stall = !prep_ready;

   gtg_prep u_prep (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .ready_out (prep_ready),
      .pos_x     (req_pos_x),
      .pos_y     (req_pos_y),
      .heading   (req_heading),
      .dest_x    (dest_x_ff),
      .dest_y    (dest_y_ff),
      .out_valid (chain_valid[0]),
      .out_data  (chain_data[0]),
      .ready_in  (chain_ready[0])
   );

   for (genvar i = 0; i < N_CELLS; i++) begin : g_cell
      gtg_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .step      (STEP_W'(i)),
         .in_valid  (chain_valid[i]),
         .in_data   (chain_data[i]),
         .ready_out (chain_ready[i]),
         .out_valid (chain_valid[i+1]),
         .out_data  (chain_data[i+1]),
         .ready_in  (chain_ready[i+1])
      );
   end

   assign chain_ready[N_CELLS] = out_ready;

   gtg_out u_out (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (chain_valid[N_CELLS]),
      .in_data      (chain_data[N_CELLS]),
      .ready_out    (out_ready),
      .gain         (gain_ff),
      .speed_limit  (speed_limit_ff),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .linear_speed (rsp_linear_speed),
      .angular_rate (rsp_angular_rate)
   );

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the go-to-goal velocity command block. Pose
// transactions are driven with random source gaps and sink stalls. Every
// accepted pose is run through an in-bench fixed-point controller model
// (integer square root, CORDIC bearing, turn or drive, speed clamp) unless
// its table row is typed, and each returned command is compared field by
// field in order. A short table of directed poses comes first, then phases
// of random poses under different target, gain and speed-limit settings.
// ----------------------------------------------------------------------------
module tb_top;
   import gtg_pkg::*;

   localparam int     Q_BITS       = 12;
   localparam int     ROTATIONS    = 16;
   localparam longint DIST_LIMIT   = ((4 << Q_BITS) + 5) / 10;
   localparam longint TURN_LIMIT   = ((2 << Q_BITS) + 5) / 10;
   localparam longint RATE_SAT     = 32767;
   localparam longint HALF_PI_Z    = 64'sd1686629713;
   localparam longint ATAN_Z [16]  = '{
      64'sd843314856, 64'sd497837829, 64'sd263043836, 64'sd133525158,
      64'sd67021686,  64'sd33543515,  64'sd16775850,  64'sd8388437,
      64'sd4194282,   64'sd2097149,   64'sd1048575,   64'sd524287,
      64'sd262143,    64'sd131071,    64'sd65535,     64'sd32767
   };
   localparam int     N_PHASES     = 8;
   localparam int     PHASE_POSES  = 160;
   localparam int     DRAIN_CYCLES = 40;
   localparam int     N_TABLE      = 19;

   typedef enum int {IDLE_NONE, IDLE_LIGHT, IDLE_HEAVY} idle_mode_type;

   typedef struct packed {
      logic [IN_W-1:0]   speed;
      logic [RATE_W-1:0] rate;
   } motion_cmd_type;

   typedef struct packed {
      logic [IN_W-1:0]          pos_x;
      logic [IN_W-1:0]          pos_y;
      logic signed [HEAD_W-1:0] heading;
      logic                     typed;
      logic [IN_W-1:0]          speed;
      logic [RATE_W-1:0]        rate;
   } pose_row_type;

   logic                     clock = 1'b0;
   logic                     reset = 1'b1;
   logic                     req_valid = 1'b0;
   logic                     req_stall;
   logic [IN_W-1:0]          req_pos_x = '0;
   logic [IN_W-1:0]          req_pos_y = '0;
   logic signed [HEAD_W-1:0] req_heading = '0;
   logic                     rsp_valid;
   logic                     rsp_stall = 1'b0;
   logic [IN_W-1:0]          rsp_linear_speed;
   logic [RATE_W-1:0]        rsp_angular_rate;
   logic                     csr_wr_en = 1'b0;
   logic [CSR_INDEX_W-1:0]   csr_index = '0;
   logic [CFG_W-1:0]         csr_wr_data = '0;

   logic [CFG_W-1:0] goal_x = 16'd4096;
   logic [CFG_W-1:0] goal_y = 16'd4096;
   logic [CFG_W-1:0] speed_gain = 16'd4096;
   logic [CFG_W-1:0] speed_cap = 16'd4096;

   logic           row_typed = 1'b0;
   motion_cmd_type row_cmd = '0;

   motion_cmd_type pending_cmds[$];
   int             error_count = 0;
   int             stall_left = 0;
   idle_mode_type  src_mode = IDLE_NONE;
   idle_mode_type  sink_mode = IDLE_NONE;

   pose_row_type pose_table [N_TABLE] = '{
      '{16'd4096,  16'd4096,  15'sd0,      1'b1, 16'd0,    15'd0},
      '{16'd5734,  16'd4096,  15'sd0,      1'b1, 16'd0,    15'd0},
      '{16'd2457,  16'd4096,  15'sd0,      1'b1, 16'd1639, 15'd0},
      '{16'd2457,  16'd4096,  15'sd819,    1'b0, 16'd0,    15'd0},
      '{16'd2457,  16'd4096,  15'sd820,    1'b0, 16'd0,    15'd0},
      '{16'd2457,  16'd4096,  15'sd12868,  1'b0, 16'd0,    15'd0},
      '{16'd2457,  16'd4096,  -15'sd12868, 1'b0, 16'd0,    15'd0},
      '{16'd0,     16'd0,     15'sd3217,   1'b0, 16'd0,    15'd0},
      '{16'd65535, 16'd65535, -15'sd9651,  1'b0, 16'd0,    15'd0},
      '{16'd65535, 16'd0,     15'sd9651,   1'b0, 16'd0,    15'd0},
      '{16'd0,     16'd65535, -15'sd3217,  1'b0, 16'd0,    15'd0},
      '{16'd65535, 16'd4096,  15'sd12868,  1'b0, 16'd0,    15'd0},
      '{16'd4096,  16'd0,     15'sd6434,   1'b0, 16'd0,    15'd0},
      '{16'd4096,  16'd65535, -15'sd6434,  1'b0, 16'd0,    15'd0},
      '{16'd3000,  16'd3000,  15'sd16383,  1'b0, 16'd0,    15'd0},
      '{16'd3000,  16'd3000,  15'h4000,    1'b0, 16'd0,    15'd0},
      '{16'd65535, 16'd65535, 15'sd0,      1'b0, 16'd0,    15'd0},
      '{16'd4096,  16'd4096,  15'sd16383,  1'b1, 16'd0,    15'd0},
      '{16'd0,     16'd0,     15'sd0,      1'b0, 16'd0,    15'd0}
   };

   go_to_goal_velocity_command u_dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_pos_x        (req_pos_x),
      .req_pos_y        (req_pos_y),
      .req_heading      (req_heading),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_linear_speed (rsp_linear_speed),
      .rsp_angular_rate (rsp_angular_rate),
      .csr_wr_en        (csr_wr_en),
      .csr_index        (csr_index),
      .csr_wr_data      (csr_wr_data)
   );

   always #4 clock = ~clock;

   initial begin
      #10_000_000;
      $display("Verification failed");
      $finish;
   end

   function automatic longint floor_sqrt(longint v);
      longint root;
      longint probe;
      root = 0;
      probe = longint'(1) << 62;
      while (probe > v)
         probe = probe >> 2;
      while (probe != 0) begin
         if (v >= root + probe) begin
            v = v - (root + probe);
            root = (root >> 1) + probe;
         end else begin
            root = root >> 1;
         end
         probe = probe >> 2;
      end
      return root;
   endfunction

   function automatic longint bearing_q12(longint dx, longint dy);
      longint x, y, z, xs, ys, t;
      x = dx * 65536;
      y = dy * 65536;
      z = 0;
      if (x < 0) begin
         t = x;
         if (y >= 0) begin
            x = y;
            y = -t;
            z = HALF_PI_Z;
         end else begin
            x = -y;
            y = t;
            z = -HALF_PI_Z;
         end
      end
      for (int i = 0; i < ROTATIONS; i++) begin
         xs = x >>> i;
         ys = y >>> i;
         if (y > 0) begin
            x = x + ys;
            y = y - xs;
            z = z + ATAN_Z[i];
         end else begin
            x = x - ys;
            y = y + xs;
            z = z - ATAN_Z[i];
         end
      end
      return (z + (longint'(1) << 17)) >>> 18;
   endfunction

   function automatic motion_cmd_type predict_motion(logic [IN_W-1:0] px, logic [IN_W-1:0] py,
                                                     logic signed [HEAD_W-1:0] hd);
      longint         dx, dy, span, err, aerr, speed, rate;
      motion_cmd_type cmd;
      dx = longint'(goal_x) - longint'(px);
      dy = longint'(goal_y) - longint'(py);
      span = floor_sqrt(dx * dx + dy * dy);
      speed = 0;
      rate = 0;
      if (span > DIST_LIMIT) begin
         err = bearing_q12(dx, dy) - longint'(hd);
         aerr = (err < 0) ? -err : err;
         if (aerr > TURN_LIMIT)
            rate = (aerr > RATE_SAT) ? RATE_SAT : aerr;
         else
            speed = (longint'(speed_gain) * span) >>> Q_BITS;
      end
      if (speed > longint'(speed_cap))
         speed = longint'(speed_cap);
      cmd.speed = speed[IN_W-1:0];
      cmd.rate = rate[RATE_W-1:0];
      return cmd;
   endfunction

   function automatic logic [IN_W-1:0] clamp16(longint v);
      if (v < 0)
         return '0;
      if (v > 65535)
         return '1;
      return v[IN_W-1:0];
   endfunction

   function automatic int pick_gap();
      if ($urandom_range(9) == 0)
         return $urandom_range(40, 10);
      return $urandom_range(3, 1);
   endfunction

   task automatic report_mismatch(input string what, input longint got, input longint want);
      $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
      error_count++;
   endtask

   task automatic write_reg(input reg_index_type idx, input logic [CFG_W-1:0] value);
      csr_wr_en <= 1'b1;
      csr_index <= idx;
      csr_wr_data <= value;
      unique case (idx)
         REG_DEST_X:      goal_x = value;
         REG_DEST_Y:      goal_y = value;
         REG_GAIN:        speed_gain = value;
         REG_SPEED_LIMIT: speed_cap = value;
      endcase
      @(negedge clock);
   endtask

   task automatic load_settings(input logic [CFG_W-1:0] tx, input logic [CFG_W-1:0] ty,
                                input logic [CFG_W-1:0] g, input logic [CFG_W-1:0] lim);
      @(negedge clock);
      write_reg(REG_DEST_X, tx);
      write_reg(REG_DEST_Y, ty);
      write_reg(REG_GAIN, g);
      write_reg(REG_SPEED_LIMIT, lim);
      csr_wr_en <= 1'b0;
   endtask

   task automatic send_pose(input logic [IN_W-1:0] px, input logic [IN_W-1:0] py,
                            input logic signed [HEAD_W-1:0] hd, input logic typed,
                            input motion_cmd_type typed_cmd);
      int gap;
      gap = 0;
      if (src_mode != IDLE_NONE &&
          $urandom_range(99) < ((src_mode == IDLE_LIGHT) ? 10 : 30))
         gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid <= 1'b1;
      req_pos_x <= px;
      req_pos_y <= py;
      req_heading <= hd;
      row_typed <= typed;
      row_cmd <= typed_cmd;
      @(posedge clock);
      while (req_stall)
         @(posedge clock);
      @(negedge clock);
   endtask

   task automatic make_pose(output logic [IN_W-1:0] px, output logic [IN_W-1:0] py,
                            output logic signed [HEAD_W-1:0] hd);
      int     kind, reach;
      longint dx, dy, h;
      kind = $urandom_range(99);
      if (kind < 60) begin
         reach = (kind < 15) ? 1800 : ((kind < 40) ? 2047 : 8191);
         dx = longint'(int'($urandom_range(2 * reach)) - reach);
         dy = longint'(int'($urandom_range(2 * reach)) - reach);
         px = clamp16(longint'(goal_x) - dx);
         py = clamp16(longint'(goal_y) - dy);
         dx = longint'(goal_x) - longint'(px);
         dy = longint'(goal_y) - longint'(py);
         if (kind < 15)
            h = longint'(int'($urandom_range(2 * 12868)) - 12868);
         else
            h = bearing_q12(dx, dy) + longint'(int'($urandom_range(3000)) - 1500);
         if (h > 16383)
            h = 16383;
         if (h < -16384)
            h = -16384;
         hd = h[HEAD_W-1:0];
      end else begin
         px = IN_W'($urandom_range(65535));
         py = IN_W'($urandom_range(65535));
         if (kind < 85)
            hd = 15'(int'($urandom_range(2 * 12868)) - 12868);
         else
            hd = HEAD_W'($urandom_range(32767));
      end
   endtask

   task automatic finish_phase();
      req_valid <= 1'b0;
      while (pending_cmds.size() != 0)
         @(posedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);
   endtask

   always @(negedge clock) begin
      if (stall_left == 0 && sink_mode != IDLE_NONE &&
          $urandom_range(99) < ((sink_mode == IDLE_LIGHT) ? 10 : 30))
         stall_left = pick_gap();
      if (stall_left > 0) begin
         rsp_stall <= 1'b1;
         stall_left--;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   always @(posedge clock) begin
      motion_cmd_type want;
      if (!reset) begin
         if (req_valid && !req_stall) begin
            if (row_typed)
               pending_cmds.push_back(row_cmd);
            else
               pending_cmds.push_back(predict_motion(req_pos_x, req_pos_y, req_heading));
         end
         if (rsp_valid && !rsp_stall) begin
            if (pending_cmds.size() == 0) begin
               report_mismatch("unexpected transaction, linear_speed", rsp_linear_speed, 0);
            end else begin
               want = pending_cmds.pop_front();
               if (rsp_linear_speed !== want.speed)
                  report_mismatch("linear_speed", rsp_linear_speed, want.speed);
               if (rsp_angular_rate !== want.rate)
                  report_mismatch("angular_rate", rsp_angular_rate, want.rate);
            end
         end
      end
   end

   initial begin
      logic [IN_W-1:0]          px, py;
      logic signed [HEAD_W-1:0] hd;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      src_mode = IDLE_LIGHT;
      sink_mode = IDLE_HEAVY;
      for (int r = 0; r < N_TABLE; r++)
         send_pose(pose_table[r].pos_x, pose_table[r].pos_y, pose_table[r].heading,
                   pose_table[r].typed, {pose_table[r].speed, pose_table[r].rate});
      finish_phase();

      for (int phase = 0; phase < N_PHASES; phase++) begin
         unique case (phase)
            0: load_settings(16'd1, 16'd1, 16'hFFFF, 16'hFFFF);
            1: load_settings(16'd49151, 16'd49151, 16'd0, 16'd0);
            2: load_settings(16'd49151, 16'd1, 16'd4096, 16'hFFFF);
            3: load_settings(16'd0, 16'hFFFF, 16'($urandom), 16'($urandom));
            default: load_settings(16'($urandom_range(49151, 1)), 16'($urandom_range(49151, 1)),
                                   16'($urandom_range(16384)), 16'($urandom));
         endcase
         src_mode = idle_mode_type'(phase % 3);
         sink_mode = idle_mode_type'((phase + 2) % 3);
         repeat (PHASE_POSES) begin
            make_pose(px, py, hd);
            send_pose(px, py, hd, 1'b0, '0);
         end
         finish_phase();
      end

      if (pending_cmds.size() != 0)
         report_mismatch("commands still pending", pending_cmds.size(), 0);
      if (error_count == 0)
         $display("Verification passed");
      else
         $display("Verification failed");
      $finish;
   end

endmodule

// ===== go_to_goal_velocity_command.f =====
rtl/gtg_pkg.sv
rtl/gtg_prep.sv
rtl/gtg_cell.sv
rtl/gtg_out.sv
rtl/go_to_goal_velocity_command.sv
tb/tb_top.sv
